/* hdl/q4k_pkg.sv */
// ----------------------------------------------------------------------------
// q4k_pkg
// Types, constants and helper functions shared by the Q4_K superblock
// dequantiser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package q4k_pkg;

    localparam int MAG_W = 52;
    localparam int LZ_W  = 6;

    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    localparam logic [7:0]  FP32_BIAS = 8'd127;

    typedef struct packed {
        logic [31:0] block_word;
        logic        tensor_end;
    } in_t;

    typedef struct packed {
        logic [31:0] value0;
        logic [31:0] value1;
        logic [31:0] value2;
        logic [31:0] value3;
        logic [31:0] value4;
        logic [31:0] value5;
        logic [31:0] value6;
        logic [31:0] value7;
        logic        block_last;
        logic        tensor_last;
    } out_t;

    typedef enum logic {
        ST_COLLECT,
        ST_BURST
    } state_t;

    // An fp16 value as sign, integer significand and power of two, so that
    // value = mant * 2^expo exactly for every finite code.
    typedef struct packed {
        logic              sgn;
        logic              nan;
        logic              inf;
        logic [10:0]       mant;
        logic signed [5:0] expo;
    } half_t;

    // Per-word controls handed from the issue stage to every lane.
    typedef struct packed {
        logic [16:0]       a;
        logic [16:0]       mm;
        logic signed [5:0] ed;
        logic signed [5:0] edm;
        logic              sd;
        logic              sdm;
        logic              d_nan;
        logic              d_inf;
        logic              dm_nan;
        logic              dm_inf;
        logic              s_zero;
    } lane_ctl_t;

    function automatic half_t half_decode(input logic [15:0] h);
        half_t       r;
        logic [4:0]  e;
        logic [9:0]  m;
        e = h[14:10];
        m = h[9:0];
        r.sgn  = h[15];
        r.nan  = (e == 5'h1F) && (m != 10'd0);
        r.inf  = (e == 5'h1F) && (m == 10'd0);
        r.mant = (e == 5'd0) ? {1'b0, m} : {1'b1, m};
        r.expo = $signed({1'b0, ((e == 5'd0) ? 5'd1 : e)}) - 6'sd25;
        return r;
    endfunction

    // Six-bit scale of a sub-block; scales 4 to 7 use bytes 3 to 5 in the
    // same layout as scales 0 to 3 use bytes 0 to 2.
    function automatic logic [5:0] scale_of(input logic [47:0] sb, input logic [2:0] idx);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [5:0] s;
        b0 = idx[2] ? sb[31:24] : sb[7:0];
        b1 = idx[2] ? sb[39:32] : sb[15:8];
        b2 = idx[2] ? sb[47:40] : sb[23:16];
        case (idx[1:0])
            2'd0:    s = b0[5:0];
            2'd1:    s = {b1[3:0], b0[7:6]};
            2'd2:    s = {b2[1:0], b1[7:4]};
            default: s = b2[7:2];
        endcase
        return s;
    endfunction

    function automatic logic [LZ_W-1:0] msb_index(input logic [MAG_W-1:0] v);
        logic [LZ_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                r = LZ_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/q4k_lane.sv */
// ----------------------------------------------------------------------------
// q4k_lane
// One dequantiser lane: exact products, alignment, one signed add, then
// normalisation with round to nearest even into fp32. Five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q4k_lane
    import q4k_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        adv,
    input  wire lane_ctl_t   ctl,
    input  wire logic [3:0]  q,
    output logic      [31:0] value
);

    // Special-value flags travel alongside the datapath.
    typedef struct packed {
        logic nan;
        logic inf;
        logic isg;
    } spec_t;

    // Stage 1
    logic [20:0]       p1_reg;
    logic [16:0]       m1_reg;
    logic signed [5:0] ed1_reg, edm1_reg;
    logic              sd1_reg, sdm1_reg;
    spec_t             sp1_reg, sp1_next;

    // Stage 2
    logic [MAG_W-1:0]  px2_reg, mx2_reg, px2_next, mx2_next;
    logic signed [5:0] em2_reg, em2_next;
    logic              sd2_reg, sdm2_reg, zs2_reg;
    spec_t             sp2_reg;

    // Stage 3
    logic [MAG_W-1:0]  mag3_reg, mag3_next;
    logic              sg3_reg, sg3_next, zs3_reg;
    logic signed [5:0] em3_reg;
    spec_t             sp3_reg;

    // Stage 4
    logic [MAG_W-1:0]  mag4_reg;
    logic [LZ_W-1:0]   l4_reg;
    logic              sg4_reg, zs4_reg;
    logic signed [5:0] em4_reg;
    spec_t             sp4_reg;

    // Stage 5
    logic [31:0]       val5_reg, val5_next;

    always_comb begin
        logic qz, p_nan, p_inf, m_nan, m_inf;
        qz    = (q == 4'd0);
        p_nan = ctl.d_nan | (ctl.d_inf & (ctl.s_zero | qz));
        p_inf = ctl.d_inf & ~ctl.s_zero & ~qz;
        m_nan = ctl.dm_nan | (ctl.dm_inf & ctl.s_zero);
        m_inf = ctl.dm_inf & ~ctl.s_zero;
        sp1_next.nan = p_nan | m_nan | (p_inf & m_inf & (ctl.sd == ctl.sdm));
        sp1_next.inf = ~sp1_next.nan & (p_inf | m_inf);
        sp1_next.isg = p_inf ? ctl.sd : ~ctl.sdm;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg   <= 21'(ctl.a) * 21'(q);
            m1_reg   <= ctl.mm;
            ed1_reg  <= ctl.ed;
            edm1_reg <= ctl.edm;
            sd1_reg  <= ctl.sd;
            sdm1_reg <= ctl.sdm;
            sp1_reg  <= sp1_next;
        end
    end

    always_comb begin
        logic [5:0] diff;
        if (ed1_reg >= edm1_reg) begin
            diff     = 6'(ed1_reg - edm1_reg);
            px2_next = MAG_W'(p1_reg) << diff;
            mx2_next = MAG_W'(m1_reg);
            em2_next = edm1_reg;
        end else begin
            diff     = 6'(edm1_reg - ed1_reg);
            px2_next = MAG_W'(p1_reg);
            mx2_next = MAG_W'(m1_reg) << diff;
            em2_next = ed1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px2_reg  <= px2_next;
            mx2_reg  <= mx2_next;
            em2_reg  <= em2_next;
            sd2_reg  <= sd1_reg;
            sdm2_reg <= sdm1_reg;
            // Only an exact sum of two zeros can give negative zero.
            zs2_reg  <= (p1_reg == '0) && (m1_reg == '0) && sd1_reg && !sdm1_reg;
            sp2_reg  <= sp1_reg;
        end
    end

    always_comb begin
        logic ge;
        ge = (px2_reg >= mx2_reg);
        if (sd2_reg == sdm2_reg) begin
            mag3_next = ge ? (px2_reg - mx2_reg) : (mx2_reg - px2_reg);
            sg3_next  = ge ? sd2_reg : ~sd2_reg;
        end else begin
            mag3_next = px2_reg + mx2_reg;
            sg3_next  = sd2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag3_reg <= mag3_next;
            sg3_reg  <= sg3_next;
            zs3_reg  <= zs2_reg;
            em3_reg  <= em2_reg;
            sp3_reg  <= sp2_reg;
            mag4_reg <= mag3_reg;
            l4_reg   <= msb_index(mag3_reg);
            sg4_reg  <= sg3_reg;
            zs4_reg  <= zs3_reg;
            em4_reg  <= em3_reg;
            sp4_reg  <= sp3_reg;
            val5_reg <= val5_next;
        end
    end

    always_comb begin
        logic [MAG_W-1:0] norm;
        logic [8:0]       ex;
        logic             inc;
        norm = mag4_reg << (LZ_W'(MAG_W - 1) - l4_reg);
        ex   = 9'({3'b000, l4_reg}) + 9'({{3{em4_reg[5]}}, em4_reg}) + 9'({1'b0, FP32_BIAS});
        inc  = norm[MAG_W-25] & (norm[MAG_W-24] | (|norm[MAG_W-26:0]));
        if (sp4_reg.nan) begin
            val5_next = FP32_QNAN;
        end else if (sp4_reg.inf) begin
            val5_next = {sp4_reg.isg, 8'hFF, 23'd0};
        end else if (mag4_reg == '0) begin
            val5_next = {zs4_reg, 31'd0};
        end else begin
            // A rounding carry out of the fraction bumps the exponent.
            val5_next = {sg4_reg, 31'({ex[7:0], norm[MAG_W-2:MAG_W-24]}) + 31'(inc)};
        end
    end

    assign value = val5_reg;

endmodule

`default_nettype wire

/* hdl/q4k_superblock_dequantizer_core.sv */
// ----------------------------------------------------------------------------
// q4k_superblock_dequantizer_core
// Collects a Q4_K superblock word by word and expands it into fp32 values.
// ----------------------------------------------------------------------------
// Usage
//   The s_ channel takes 36 words per superblock: three scale words, the
//   quant words, then a word holding fp16 d (low half) and dmin (high half).
//   One word is taken per cycle while words are being collected.
//   On the final word the block issues one result per quant word, each a
//   transaction of eight fp32 values, with block_last on the final one and
//   tensor_last on it too when tensor_end was seen in that superblock.
//   The first result follows the final word through the burst state, the quant
//   read register and the five lane stages; a burst of 32 results then runs at
//   one per cycle while the output is not stalled, set by the single read port
//   of the quant store feeding eight parallel lanes of a five-stage pipeline.
//   Input is refused during the burst issue.
//   Words of the next superblock are taken while the pipeline drains; its
//   final word waits until every result of the previous one has left.
//   When m_ready is low while a result waits, the whole pipeline holds; nothing is lost.
//   Reset clears the state, the word position, the burst index, the pending tensor end and all valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q4k_superblock_dequantizer_core
    import q4k_pkg::*;
#(
    parameter int VALUES_PER_BLOCK = 256
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int QWORDS    = VALUES_PER_BLOCK / 8;
    localparam int LAST_WORD = 3 + QWORDS;
    localparam int AW        = $clog2(QWORDS);
    localparam int PW        = $clog2(LAST_WORD + 1);
    localparam int DEPTH     = 6;

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg;
    logic [AW-1:0]     k_reg;
    logic              pend_reg;
    logic              btl_reg;
    logic [47:0]       sc_reg;
    half_t             d_reg, dm_reg;
    logic [31:0]       qmem [QWORDS];
    logic [31:0]       qw_reg;
    lane_ctl_t         ctl_reg, ctl_next;
    logic [DEPTH-1:0]  vld_reg, bl_reg, tl_reg;
    logic [31:0]       lane_val [8];

    logic s_fire, adv, busy, issue, at_last;

    assign busy    = |vld_reg;
    assign adv     = !vld_reg[DEPTH-1] || m_ready;
    assign at_last = (pos_reg == PW'(LAST_WORD));
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: if (s_fire && at_last) state_next = ST_BURST;
            ST_BURST:   if (adv && k_reg == AW'(QWORDS - 1)) state_next = ST_COLLECT;
            default:    state_next = ST_COLLECT;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        unique case (state_reg)
            ST_COLLECT: s_ready = !(at_last && busy);
            ST_BURST:   issue   = adv;
            default:    s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            pos_reg   <= '0;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
            vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                if (at_last) begin
                    pos_reg  <= '0;
                    pend_reg <= 1'b0;
                end else begin
                    pos_reg  <= pos_reg + PW'(1);
                    pend_reg <= pend_reg | s_data.tensor_end;
                end
            end
            if (issue) begin
                k_reg <= k_reg + AW'(1);
            end
            if (adv) begin
                vld_reg <= {vld_reg[DEPTH-2:0], issue};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (pos_reg == PW'(0)) begin
                sc_reg[31:0] <= s_data.block_word;
            end
            if (pos_reg == PW'(1)) begin
                sc_reg[47:32] <= s_data.block_word[15:0];
            end
            if (at_last) begin
                d_reg   <= half_decode(s_data.block_word[15:0]);
                dm_reg  <= half_decode(s_data.block_word[31:16]);
                btl_reg <= s_data.tensor_end | pend_reg;
            end
        end
        if (adv) begin
            bl_reg  <= {bl_reg[DEPTH-2:0], issue && k_reg == AW'(QWORDS - 1)};
            tl_reg  <= {tl_reg[DEPTH-2:0], issue && k_reg == AW'(QWORDS - 1) && btl_reg};
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && pos_reg >= PW'(3) && !at_last) begin
            qmem[AW'(pos_reg - PW'(3))] <= s_data.block_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qw_reg <= qmem[k_reg];
        end
    end

    always_comb begin
        logic [5:0] s;
        s = scale_of(sc_reg, 3'(k_reg >> 2));
        ctl_next.a      = 17'(d_reg.mant) * 17'(s);
        ctl_next.mm     = 17'(dm_reg.mant) * 17'(s);
        ctl_next.ed     = d_reg.expo;
        ctl_next.edm    = dm_reg.expo;
        ctl_next.sd     = d_reg.sgn;
        ctl_next.sdm    = dm_reg.sgn;
        ctl_next.d_nan  = d_reg.nan;
        ctl_next.d_inf  = d_reg.inf;
        ctl_next.dm_nan = dm_reg.nan;
        ctl_next.dm_inf = dm_reg.inf;
        ctl_next.s_zero = (s == 6'd0);
    end

    for (genvar j = 0; j < 8; j++) begin : g_lane
        q4k_lane u_lane (
            .aclk  (aclk),
            .adv   (adv),
            .ctl   (ctl_reg),
            .q     (qw_reg[4*j +: 4]),
            .value (lane_val[j])
        );
    end

    // The lanes' results are gathered into one result transaction.
    assign m_valid            = vld_reg[DEPTH-1];
    assign m_data.value0      = lane_val[0];
    assign m_data.value1      = lane_val[1];
    assign m_data.value2      = lane_val[2];
    assign m_data.value3      = lane_val[3];
    assign m_data.value4      = lane_val[4];
    assign m_data.value5      = lane_val[5];
    assign m_data.value6      = lane_val[6];
    assign m_data.value7      = lane_val[7];
    assign m_data.block_last  = bl_reg[DEPTH-1];
    assign m_data.tensor_last = tl_reg[DEPTH-1];

endmodule

`default_nettype wire

/* hdl/q4k_checker.sv */
// ----------------------------------------------------------------------------
// q4k_checker
// Port-level checks on the dequantiser's input and result channels, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q4k_checker
    import q4k_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_tensor_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tensor_last |-> m_data.block_last)
        else $error("tensor end flagged away from a block end");

    a_burst_dense: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.block_last |=> m_valid)
        else $error("gap inside a result burst");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction changed while waiting");

endmodule

bind q4k_superblock_dequantizer_core q4k_checker u_q4k_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
